// ===== rtl/ihpq_pkg.sv =====
// Package for the interval heap priority queue: key type, command and
// status codes, sequencer states and the compare unit's result struct.
// No dependencies.
`default_nettype none

package ihpq_pkg;

    localparam int KEY_W   = 31;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 8;

    typedef logic [KEY_W-1:0] key_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DEL_RD,
        S_RM_START,
        S_RM_ROOT2,
        S_RM_LAST,
        S_RM_CHILD,
        S_RM_C0,
        S_RM_C1,
        S_RM_EVAL,
        S_RM_SWAP,
        S_RM_FINAL,
        S_RM_DONE,
        S_INS_START,
        S_INS_RD,
        S_INS_HI,
        S_UP_STEP,
        S_UP_CMP,
        S_SC_RD,
        S_SC_LO,
        S_SC_HI,
        S_PATH_STEP,
        S_PATH_WR,
        S_FIN_RD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } cmp_res_t;

endpackage

`default_nettype wire

// ===== rtl/interval_heap_double_ended_pq.sv =====
// Interval heap double-ended priority queue.
// Depends on ihpq_pkg, ihpq_ram and ihpq_cmp.
//
// Input channel s_*: one beat carries a command (insert, delete min and max,
// update key or no-op). Output channel m_*: one result beat per command with the
// status, the removed ends, the min and max after the command and the count.
// The block works on one command at a time: s_tready is high only while the
// sequencer is idle, which may be while the previous result still waits on
// m_tready in the output register.
// A small sequencer drives two node memories (low ends, high ends, one read
// and one write each per cycle) and one shared comparator. An insert sifts
// the new key up level by level, a delete sifts down from the root on each
// side in turn, and an update scans the nodes for its key and copies the
// root path before its delete and insert.
// Reset empties the queue (count zero); memories are not cleared, only
// occupied slots are ever used. When m_tready is low the result holds and the
// finished command waits in its last state.
`default_nettype none

module interval_heap_double_ended_pq #(
    parameter int CAPACITY_PAIRS = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [1:0] cmd, [32:2] key, [63:33] new_key
    input  wire [63:0]  s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [1:0] status, [32:2] removed_low, [63:33] removed_high,
    // [94:64] min_value, [125:95] max_value, [133:126] count, [135:134] zero
    output logic [135:0] m_tdata
);
    import ihpq_pkg::*;

    localparam int AW = $clog2(CAPACITY_PAIRS);
    localparam int IW = AW + 1;
    localparam int CW = $clog2(2 * CAPACITY_PAIRS + 1);
    localparam int XW = CW + 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(2 * CAPACITY_PAIRS);

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic [AW-1:0]   c_reg, c_next;
    logic [IW-1:0]   idx_reg, idx_next;
    key_t            y_reg, y_next;
    key_t            clo_reg, clo_next;
    key_t            chi_reg, chi_next;
    logic            dir_reg, dir_next;     // 0: low ends (min side), 1: high ends
    cmd_t            cmd_reg, cmd_next;
    key_t            key_reg, key_next;
    key_t            nkey_reg, nkey_next;
    status_t         stat_reg, stat_next;
    key_t            rlo_reg, rlo_next;
    key_t            rhi_reg, rhi_next;

    logic            m_valid_reg, m_valid_next;
    logic [135:0]    m_data_reg, m_data_next;

    logic            lo_we, hi_we, rd_en;
    logic [AW-1:0]   lo_wa, hi_wa, rd_addr;
    key_t            lo_wd, hi_wd, lo_q, hi_q;
    key_t            cmp_a, cmp_b;
    cmp_res_t        cr;

    logic [XW-1:0]   nodes_w, c_w, cnt_w;
    logic [CW-1:0]   last_w, p_w;
    logic [AW-1:0]   pos_parent;
    logic            pos_pair, c_pair, c1_pair, idx_pair;
    key_t            top_q;

    ihpq_ram #(.DEPTH(CAPACITY_PAIRS), .AW(AW)) u_low (
        .clk(clk), .we(lo_we), .waddr(lo_wa), .wdata(lo_wd),
        .re(rd_en), .raddr(rd_addr), .rdata(lo_q)
    );

    ihpq_ram #(.DEPTH(CAPACITY_PAIRS), .AW(AW)) u_high (
        .clk(clk), .we(hi_we), .waddr(hi_wa), .wdata(hi_wd),
        .re(rd_en), .raddr(rd_addr), .rdata(hi_q)
    );

    ihpq_cmp u_cmp (.a(cmp_a), .b(cmp_b), .res(cr));

    assign cnt_w      = XW'(cnt_reg);
    assign nodes_w    = (cnt_w + XW'(1)) >> 1;
    assign c_w        = XW'({pos_reg, 1'b1});
    assign last_w     = (cnt_reg - CW'(1)) >> 1;
    assign p_w        = cnt_reg >> 1;
    assign pos_parent = (pos_reg - AW'(1)) >> 1;
    assign pos_pair   = (XW'({pos_reg, 1'b0}) + XW'(2)) <= cnt_w;
    assign c_pair     = (XW'({c_reg, 1'b0}) + XW'(2)) <= cnt_w;
    assign c1_pair    = (XW'({c_reg, 1'b0}) + XW'(4)) <= cnt_w;
    assign idx_pair   = (XW'({idx_reg, 1'b0}) + XW'(2)) <= cnt_w;
    assign top_q      = c1_pair ? hi_q : lo_q;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        c_reg      <= c_next;
        idx_reg    <= idx_next;
        y_reg      <= y_next;
        clo_reg    <= clo_next;
        chi_reg    <= chi_next;
        dir_reg    <= dir_next;
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        nkey_reg   <= nkey_next;
        stat_reg   <= stat_next;
        rlo_reg    <= rlo_next;
        rhi_reg    <= rhi_next;
        m_data_reg <= m_data_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        c_next       = c_reg;
        idx_next     = idx_reg;
        y_next       = y_reg;
        clo_next     = clo_reg;
        chi_next     = chi_reg;
        dir_next     = dir_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        nkey_next    = nkey_reg;
        stat_next    = stat_reg;
        rlo_next     = rlo_reg;
        rhi_next     = rhi_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        lo_we   = 1'b0;
        lo_wa   = pos_reg;
        lo_wd   = y_reg;
        hi_we   = 1'b0;
        hi_wa   = pos_reg;
        hi_wd   = y_reg;
        rd_en   = 1'b0;
        rd_addr = '0;
        cmp_a   = y_reg;
        cmp_b   = lo_q;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next  = cmd_t'(s_tdata[1:0]);
                    key_next  = s_tdata[32:2];
                    nkey_next = s_tdata[63:33];
                    y_next    = s_tdata[32:2];
                    stat_next = ST_OK;
                    rlo_next  = '0;
                    rhi_next  = '0;
                    idx_next  = '0;
                    unique case (cmd_t'(s_tdata[1:0]))
                        CMD_INSERT:
                        begin
                            if (cnt_reg >= FULL_CNT)
                            begin
                                stat_next  = ST_FULL;
                                state_next = S_FIN_RD;
                            end
                            else
                            begin
                                state_next = S_INS_START;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                stat_next  = ST_EMPTY;
                                state_next = S_FIN_RD;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = S_DEL_RD;
                            end
                        end
                        CMD_UPDATE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                stat_next  = ST_EMPTY;
                                state_next = S_FIN_RD;
                            end
                            else
                            begin
                                state_next = S_SC_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN_RD;
                        end
                    endcase
                end
            end

            S_DEL_RD:
            begin
                rlo_next   = lo_q;
                rhi_next   = (cnt_reg == CW'(1)) ? lo_q : hi_q;
                dir_next   = 1'b0;
                state_next = S_RM_START;
            end

            S_RM_START:
            begin
                if (cnt_reg <= CW'(2))
                begin
                    if (!dir_reg && cnt_reg == CW'(2))
                    begin
                        rd_en      = 1'b1;
                        state_next = S_RM_ROOT2;
                    end
                    else
                    begin
                        if (cnt_reg != '0)
                        begin
                            cnt_next = cnt_reg - CW'(1);
                        end
                        state_next = S_RM_DONE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = last_w[AW-1:0];
                    pos_next   = last_w[AW-1:0];
                    state_next = S_RM_LAST;
                end
            end

            S_RM_ROOT2:
            begin
                lo_we      = 1'b1;
                lo_wa      = '0;
                lo_wd      = hi_q;
                cnt_next   = CW'(1);
                state_next = S_RM_DONE;
            end

            S_RM_LAST:
            begin
                // pull the last key out, then sift it down from the root
                if (!dir_reg)
                begin
                    y_next = lo_q;
                    if (!cnt_reg[0])
                    begin
                        lo_we = 1'b1;
                        lo_wd = hi_q;
                    end
                end
                else
                begin
                    y_next = cnt_reg[0] ? lo_q : hi_q;
                end
                cnt_next   = cnt_reg - CW'(1);
                pos_next   = '0;
                state_next = S_RM_CHILD;
            end

            S_RM_CHILD:
            begin
                if (c_w >= nodes_w)
                begin
                    state_next = S_RM_FINAL;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = c_w[AW-1:0];
                    c_next     = c_w[AW-1:0];
                    state_next = S_RM_C0;
                end
            end

            S_RM_C0:
            begin
                clo_next = dir_reg ? (c_pair ? hi_q : lo_q) : lo_q;
                chi_next = dir_reg ? lo_q : hi_q;
                if (XW'(c_reg) + XW'(1) < nodes_w)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = c_reg + AW'(1);
                    state_next = S_RM_C1;
                end
                else
                begin
                    state_next = S_RM_EVAL;
                end
            end

            S_RM_C1:
            begin
                cmp_a = dir_reg ? top_q : lo_q;
                cmp_b = clo_reg;
                if (dir_reg ? cr.gt : cr.lt)
                begin
                    clo_next = cmp_a;
                    chi_next = dir_reg ? lo_q : hi_q;
                    c_next   = c_reg + AW'(1);
                end
                state_next = S_RM_EVAL;
            end

            S_RM_EVAL:
            begin
                cmp_a = y_reg;
                cmp_b = clo_reg;
                if (dir_reg ? !cr.lt : !cr.gt)
                begin
                    state_next = S_RM_FINAL;
                end
                else
                begin
                    if (dir_reg)
                    begin
                        hi_we = 1'b1;
                        hi_wd = clo_reg;
                    end
                    else
                    begin
                        lo_we = 1'b1;
                        lo_wd = clo_reg;
                    end
                    pos_next   = c_reg;
                    state_next = S_RM_SWAP;
                end
            end

            S_RM_SWAP:
            begin
                cmp_a = y_reg;
                cmp_b = chi_reg;
                if (pos_pair && (dir_reg ? cr.lt : cr.gt))
                begin
                    if (dir_reg)
                    begin
                        lo_we = 1'b1;
                    end
                    else
                    begin
                        hi_we = 1'b1;
                    end
                    y_next = chi_reg;
                end
                state_next = S_RM_CHILD;
            end

            S_RM_FINAL:
            begin
                if (dir_reg && pos_pair)
                begin
                    hi_we = 1'b1;
                end
                else
                begin
                    lo_we = 1'b1;
                end
                state_next = S_RM_DONE;
            end

            S_RM_DONE:
            begin
                if (cmd_reg == CMD_DELETE)
                begin
                    if (!dir_reg)
                    begin
                        dir_next   = 1'b1;
                        state_next = S_RM_START;
                    end
                    else
                    begin
                        state_next = S_FIN_RD;
                    end
                end
                else
                begin
                    y_next     = nkey_reg;
                    state_next = S_INS_START;
                end
            end

            S_INS_START:
            begin
                if (cnt_reg == '0)
                begin
                    lo_we      = 1'b1;
                    lo_wa      = '0;
                    cnt_next   = CW'(1);
                    state_next = S_FIN_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cnt_reg[0] ? p_w[AW-1:0]
                                            : AW'((p_w - CW'(1)) >> 1);
                    pos_next   = p_w[AW-1:0];
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_INS_RD;
                end
            end

            S_INS_RD:
            begin
                cmp_a = y_reg;
                cmp_b = lo_q;
                if (!cnt_reg[0])
                begin
                    // new key joins a lone key in the last node
                    if (cr.lt)
                    begin
                        hi_we    = 1'b1;
                        hi_wd    = lo_q;
                        dir_next = 1'b0;
                    end
                    else
                    begin
                        dir_next = 1'b1;
                    end
                    state_next = S_UP_STEP;
                end
                else if (cr.lt)
                begin
                    dir_next   = 1'b0;
                    state_next = S_UP_STEP;
                end
                else
                begin
                    state_next = S_INS_HI;
                end
            end

            S_INS_HI:
            begin
                cmp_a = y_reg;
                cmp_b = hi_q;
                if (cr.gt)
                begin
                    lo_we      = 1'b1;
                    lo_wd      = hi_q;
                    pos_next   = pos_parent;
                    dir_next   = 1'b1;
                    state_next = S_UP_STEP;
                end
                else
                begin
                    lo_we      = 1'b1;
                    state_next = S_FIN_RD;
                end
            end

            S_UP_STEP:
            begin
                if (pos_reg == '0)
                begin
                    if (dir_reg)
                    begin
                        hi_we = 1'b1;
                    end
                    else
                    begin
                        lo_we = 1'b1;
                    end
                    state_next = S_FIN_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = pos_parent;
                    c_next     = pos_parent;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                cmp_a = y_reg;
                cmp_b = dir_reg ? hi_q : lo_q;
                if (dir_reg ? cr.gt : cr.lt)
                begin
                    if (dir_reg)
                    begin
                        hi_we = 1'b1;
                        hi_wd = hi_q;
                    end
                    else
                    begin
                        lo_we = 1'b1;
                        lo_wd = lo_q;
                    end
                    pos_next   = c_reg;
                    state_next = S_UP_STEP;
                end
                else
                begin
                    if (dir_reg)
                    begin
                        hi_we = 1'b1;
                    end
                    else
                    begin
                        lo_we = 1'b1;
                    end
                    state_next = S_FIN_RD;
                end
            end

            S_SC_RD:
            begin
                if (XW'(idx_reg) >= nodes_w)
                begin
                    stat_next  = ST_NOTFOUND;
                    state_next = S_FIN_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg[AW-1:0];
                    state_next = S_SC_LO;
                end
            end

            S_SC_LO:
            begin
                cmp_a = key_reg;
                cmp_b = lo_q;
                if (cr.eq)
                begin
                    pos_next   = idx_reg[AW-1:0];
                    dir_next   = 1'b0;
                    state_next = S_PATH_STEP;
                end
                else if (idx_pair)
                begin
                    state_next = S_SC_HI;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_SC_RD;
                end
            end

            S_SC_HI:
            begin
                cmp_a = key_reg;
                cmp_b = hi_q;
                if (cr.eq)
                begin
                    pos_next   = idx_reg[AW-1:0];
                    dir_next   = 1'b1;
                    state_next = S_PATH_STEP;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_SC_RD;
                end
            end

            S_PATH_STEP:
            begin
                // shift ancestors down over the found key, then drop the root end
                if (pos_reg == '0)
                begin
                    state_next = S_RM_START;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = pos_parent;
                    c_next     = pos_parent;
                    state_next = S_PATH_WR;
                end
            end

            S_PATH_WR:
            begin
                if (dir_reg)
                begin
                    hi_we = 1'b1;
                    hi_wd = hi_q;
                end
                else
                begin
                    lo_we = 1'b1;
                    lo_wd = lo_q;
                end
                pos_next   = c_reg;
                state_next = S_PATH_STEP;
            end

            S_FIN_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next        = 1'b1;
                    m_data_next         = '0;
                    m_data_next[1:0]    = stat_reg;
                    m_data_next[32:2]   = rlo_reg;
                    m_data_next[63:33]  = rhi_reg;
                    if (cnt_reg != '0)
                    begin
                        m_data_next[94:64]  = lo_q;
                        m_data_next[125:95] = (cnt_reg == CW'(1)) ? lo_q : hi_q;
                    end
                    m_data_next[133:126] = COUNT_W'(cnt_reg);
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("element count above capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a second command while busy");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_data_reg[1:0] == ST_EMPTY |-> m_data_reg[133:126] == '0)
        else $error("empty status with nonzero count");

endmodule

`default_nettype wire

// ===== rtl/ihpq_ram.sv =====
// Single-port-write, single-port-read memory with registered read data.
// Holds one end (low or high) of every heap node. Uses ihpq_pkg.
`default_nettype none

module ihpq_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire                  clk,
    input  wire                  we,
    input  wire [AW-1:0]         waddr,
    input  wire ihpq_pkg::key_t  wdata,
    input  wire                  re,
    input  wire [AW-1:0]         raddr,
    output ihpq_pkg::key_t       rdata
);
    import ihpq_pkg::*;

    key_t mem [DEPTH];
    key_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data until the next read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/ihpq_cmp.sv =====
// Shared key comparator used by the sift, search and insert steps.
// Uses ihpq_pkg.
`default_nettype none

module ihpq_cmp (
    input  wire ihpq_pkg::key_t     a,
    input  wire ihpq_pkg::key_t     b,
    output ihpq_pkg::cmp_res_t      res
);
    import ihpq_pkg::*;

    always_comb
    begin
        res.lt = (a < b);
        res.eq = (a == b);
        res.gt = (a > b);
    end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for interval_heap_double_ended_pq: random and directed commands
// checked against an in-bench interval heap predictor.
// Depends on ihpq_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb;
    import ihpq_pkg::*;

    localparam int PAIRS = 64;
    localparam int KEYS_MAX = 2 * PAIRS;

    // highest field first, so the layout matches m_tdata
    typedef struct packed {
        logic [7:0] cnt;
        key_t       max_v;
        key_t       min_v;
        key_t       rm_hi;
        key_t       rm_lo;
        logic [1:0] status;
    } heap_result_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;

    interval_heap_double_ended_pq #(.CAPACITY_PAIRS(PAIRS)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor state
    key_t        lo_end [PAIRS];
    key_t        hi_end [PAIRS];
    int unsigned n_keys;

    heap_result_t expected_results [$];
    int errors;
    int n_sent;
    int n_checked;
    int n_deletes;
    int n_updates;
    int n_full;
    int send_idle_pct;
    int recv_stall_pct;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit is_pair(int unsigned i);
        return 2 * i + 2 <= n_keys;
    endfunction

    function automatic key_t top_of(int unsigned i);
        return is_pair(i) ? hi_end[i] : lo_end[i];
    endfunction

    function automatic void lo_up(int unsigned pos, key_t k);
        int unsigned q;
        while (pos > 0)
        begin
            q = (pos - 1) / 2;
            if (lo_end[q] <= k)
                break;
            lo_end[pos] = lo_end[q];
            pos = q;
        end
        lo_end[pos] = k;
    endfunction

    function automatic void hi_up(int unsigned pos, key_t k);
        int unsigned q;
        while (pos > 0)
        begin
            q = (pos - 1) / 2;
            if (hi_end[q] >= k)
                break;
            hi_end[pos] = hi_end[q];
            pos = q;
        end
        hi_end[pos] = k;
    endfunction

    function automatic void heap_add(key_t k);
        int unsigned n;
        int unsigned p;
        int unsigned q;
        n = n_keys;
        p = n / 2;
        if (n == 0)
        begin
            lo_end[0] = k;
            n_keys = 1;
            return;
        end
        n_keys = n + 1;
        if (n % 2 == 1)
        begin
            if (k < lo_end[p])
            begin
                hi_end[p] = lo_end[p];
                lo_up(p, k);
            end
            else
                hi_up(p, k);
        end
        else
        begin
            q = (p - 1) / 2;
            if (k < lo_end[q])
                lo_up(p, k);
            else if (k > hi_end[q])
            begin
                lo_end[p] = hi_end[q];
                hi_up(q, k);
            end
            else
                lo_end[p] = k;
        end
    endfunction

    function automatic void drop_min();
        int unsigned n;
        int unsigned last;
        int unsigned nodes;
        int unsigned pos;
        int unsigned c;
        key_t y;
        key_t t;
        n = n_keys;
        if (n <= 2)
        begin
            if (n == 2)
                lo_end[0] = hi_end[0];
            if (n > 0)
                n_keys = n - 1;
            return;
        end
        last = (n - 1) / 2;
        y = lo_end[last];
        if (n % 2 == 0)
            lo_end[last] = hi_end[last];
        n_keys = n - 1;
        nodes = (n_keys + 1) / 2;
        pos = 0;
        forever
        begin
            c = 2 * pos + 1;
            if (c >= nodes)
                break;
            if (c + 1 < nodes && lo_end[c + 1] < lo_end[c])
                c++;
            if (y <= lo_end[c])
                break;
            lo_end[pos] = lo_end[c];
            pos = c;
            if (is_pair(pos) && y > hi_end[pos])
            begin
                t = hi_end[pos];
                hi_end[pos] = y;
                y = t;
            end
        end
        lo_end[pos] = y;
    endfunction

    function automatic void drop_max();
        int unsigned n;
        int unsigned last;
        int unsigned nodes;
        int unsigned pos;
        int unsigned c;
        key_t y;
        key_t t;
        key_t hc;
        n = n_keys;
        if (n <= 2)
        begin
            if (n > 0)
                n_keys = n - 1;
            return;
        end
        last = (n - 1) / 2;
        y = (n % 2 == 1) ? lo_end[last] : hi_end[last];
        n_keys = n - 1;
        nodes = (n_keys + 1) / 2;
        pos = 0;
        forever
        begin
            c = 2 * pos + 1;
            if (c >= nodes)
                break;
            hc = top_of(c);
            if (c + 1 < nodes && top_of(c + 1) > hc)
            begin
                c++;
                hc = top_of(c);
            end
            if (y >= hc)
                break;
            hi_end[pos] = hc;
            pos = c;
            if (is_pair(pos) && y < lo_end[pos])
            begin
                t = lo_end[pos];
                lo_end[pos] = y;
                y = t;
            end
        end
        if (is_pair(pos))
            hi_end[pos] = y;
        else
            lo_end[pos] = y;
    endfunction

    function automatic logic [1:0] replace_key(key_t k, key_t nk);
        int unsigned nodes;
        int unsigned pos;
        int unsigned q;
        nodes = (n_keys + 1) / 2;
        for (int unsigned i = 0; i < nodes; i++)
        begin
            pos = i;
            if (lo_end[i] == k)
            begin
                // pull the root down the path, then remove it
                while (pos > 0)
                begin
                    q = (pos - 1) / 2;
                    lo_end[pos] = lo_end[q];
                    pos = q;
                end
                drop_min();
                heap_add(nk);
                return ST_OK;
            end
            if (is_pair(i) && hi_end[i] == k)
            begin
                while (pos > 0)
                begin
                    q = (pos - 1) / 2;
                    hi_end[pos] = hi_end[q];
                    pos = q;
                end
                drop_max();
                heap_add(nk);
                return ST_OK;
            end
        end
        return ST_NOTFOUND;
    endfunction

    function automatic heap_result_t predict_command(cmd_t c, key_t k, key_t nk);
        heap_result_t r;
        r = '0;
        r.status = ST_OK;
        case (c)
            CMD_INSERT:
                if (n_keys >= KEYS_MAX)
                    r.status = ST_FULL;
                else
                    heap_add(k);
            CMD_DELETE:
                if (n_keys == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.rm_lo = lo_end[0];
                    r.rm_hi = (n_keys == 1) ? lo_end[0] : hi_end[0];
                    drop_min();
                    drop_max();
                end
            CMD_UPDATE:
                if (n_keys == 0)
                    r.status = ST_EMPTY;
                else
                    r.status = replace_key(k, nk);
            default: ;
        endcase
        if (n_keys > 0)
        begin
            r.min_v = lo_end[0];
            r.max_v = (n_keys == 1) ? lo_end[0] : hi_end[0];
        end
        r.cnt = n_keys[7:0];
        return r;
    endfunction

    // pick a key currently stored, for updates that hit
    function automatic key_t stored_key();
        int unsigned slot;
        if (n_keys == 0)
            return key_t'($urandom);
        slot = $urandom_range(n_keys - 1);
        return (slot % 2 == 0) ? lo_end[slot / 2] : hi_end[slot / 2];
    endfunction

    task automatic send_command(cmd_t c, key_t k, key_t nk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {nk, k, c};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(predict_command(c, k, nk));
        n_sent++;
        if (c == CMD_DELETE)
            n_deletes++;
        if (c == CMD_UPDATE)
            n_updates++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (expected_results.size() != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
    endtask

    always @(posedge clk)
    begin
        heap_result_t got;
        heap_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[133:0];
            n_checked++;
            if (m_tdata[135:134] != 2'b00)
            begin
                $display("%0t: pad bits expected 0 actual %b", $time, m_tdata[135:134]);
                errors++;
            end
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result beat actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status != want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             got.status);
                    errors++;
                end
                if (got.rm_lo != want.rm_lo)
                begin
                    $display("%0t: removed_low expected %0d actual %0d", $time,
                             want.rm_lo, got.rm_lo);
                    errors++;
                end
                if (got.rm_hi != want.rm_hi)
                begin
                    $display("%0t: removed_high expected %0d actual %0d", $time,
                             want.rm_hi, got.rm_hi);
                    errors++;
                end
                if (got.min_v != want.min_v)
                begin
                    $display("%0t: min_value expected %0d actual %0d", $time,
                             want.min_v, got.min_v);
                    errors++;
                end
                if (got.max_v != want.max_v)
                begin
                    $display("%0t: max_value expected %0d actual %0d", $time,
                             want.max_v, got.max_v);
                    errors++;
                end
                if (got.cnt != want.cnt)
                begin
                    $display("%0t: count expected %0d actual %0d", $time, want.cnt,
                             got.cnt);
                    errors++;
                end
            end
        end
    end

    // receiver stall, redrawn each falling edge
    always @(negedge clk)
    begin
        if (recv_stall_pct > 0)
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        else
            m_tready <= 1'b1;
    end

    task automatic test_directed();
        key_t kmax;
        kmax = '1;
        send_command(CMD_DELETE, '0, '0);                   // delete on empty
        send_command(CMD_UPDATE, key_t'(5), key_t'(6));     // update on empty
        send_command(CMD_NOP, kmax, kmax);
        send_command(CMD_INSERT, kmax, '0);
        send_command(CMD_DELETE, '0, '0);                   // single key removed alone
        send_command(CMD_INSERT, '0, '0);
        send_command(CMD_INSERT, kmax, '0);
        send_command(CMD_INSERT, key_t'(1000), '0);
        send_command(CMD_INSERT, key_t'(1000), '0);         // duplicate
        send_command(CMD_UPDATE, key_t'(1000), key_t'(7));
        send_command(CMD_UPDATE, key_t'(12345), key_t'(1)); // absent key
        send_command(CMD_UPDATE, '0, kmax);
        send_command(CMD_UPDATE, kmax, '0);
        send_command(CMD_NOP, '0, '0);
        send_command(CMD_DELETE, '0, '0);
        send_command(CMD_DELETE, '0, '0);
        send_command(CMD_DELETE, '0, '0);
        drain();
    endtask

    // fill to capacity, overflow, then empty it again
    task automatic test_full();
        for (int i = 0; i < KEYS_MAX + 3; i++)
        begin
            if (n_keys >= KEYS_MAX)
                n_full++;
            send_command(CMD_INSERT, key_t'($urandom), '0);
        end
        send_command(CMD_UPDATE, stored_key(), key_t'($urandom));
        while (n_keys > 0)
            send_command(CMD_DELETE, '0, '0);
        drain();
    endtask

    task automatic test_random(int items, int idle_pct, int stall_pct);
        int pick;
        key_t k;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < items; i++)
        begin
            pick = $urandom_range(99);
            // small key range sometimes, to get duplicates
            k = ($urandom_range(3) == 0) ? key_t'($urandom_range(15)) : key_t'($urandom);
            if (pick < 50)
                send_command(CMD_INSERT, k, '0);
            else if (pick < 70)
                send_command(CMD_DELETE, k, key_t'($urandom));
            else if (pick < 88)
                send_command(CMD_UPDATE, stored_key(), k);
            else if (pick < 96)
                send_command(CMD_UPDATE, k, key_t'($urandom));
            else
                send_command(CMD_NOP, k, key_t'($urandom));
        end
        drain();
    endtask

    initial begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        errors         = 0;
        n_sent         = 0;
        n_checked      = 0;
        n_deletes      = 0;
        n_updates      = 0;
        n_full         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        n_keys         = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_full();
        test_random(100, 0, 0);
        test_random(80, 50, 0);
        test_random(80, 0, 50);
        test_random(80, 8, 8);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain();
        repeat (400) @(posedge clk);

        $display("Sent %0d commands (%0d deletes, %0d updates, %0d overflow inserts),",
                 n_sent, n_deletes, n_updates, n_full);
        $display("checked %0d result beats with %0d mismatches.", n_checked, errors);
        if (errors == 0 && expected_results.size() == 0)
            $display("interval_heap_double_ended_pq verification clean");
        else
            $display("interval_heap_double_ended_pq verification failed");
        $finish;
    end

    initial begin
        #5000000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("interval_heap_double_ended_pq verification failed");
        $finish;
    end
endmodule
